>>> rtl/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared types and constants for the framed message parser.
// ----------------------------------------------------------------------------
package fmp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned POS_W   = 17;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned CSR_IDX_W = 2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GOOD      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CSUM_ERR  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LEN_ERR   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd249;

   // frame positions before the payload
   localparam logic [POS_W-1:0] POS_SYNC_FIRST  = 17'd0;
   localparam logic [POS_W-1:0] POS_SYNC_SECOND = 17'd1;
   localparam logic [POS_W-1:0] POS_ID          = 17'd2;
   localparam logic [POS_W-1:0] POS_LEN_LOW     = 17'd3;
   localparam logic [POS_W-1:0] POS_LEN_HIGH    = 17'd4;
   localparam logic [POS_W-1:0] HEADER_BYTES    = 17'd5;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
      logic [LEN_W-1:0]  max_payload;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] message_id;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  payload_index;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

endpackage

>>> rtl/fmp_csr.sv
// ----------------------------------------------------------------------------
// fmp_csr
// Configuration registers: sync bytes and payload length limit.
// ----------------------------------------------------------------------------
module fmp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [fmp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fmp_pkg::LEN_W-1:0]         csr_wdata,
   output fmp_pkg::cfg_type                  cfg
);

   fmp_pkg::cfg_type cfg_ff;
   fmp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            fmp_pkg::CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_wdata[fmp_pkg::BYTE_W-1:0];
            fmp_pkg::CSR_SYNC_SECOND: cfg_in.sync_second = csr_wdata[fmp_pkg::BYTE_W-1:0];
            fmp_pkg::CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= '0;
         cfg_ff.sync_second <= '0;
         cfg_ff.max_payload <= fmp_pkg::MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/fmp_parser.sv
// ----------------------------------------------------------------------------
// fmp_parser
// Frame state and per-byte step: sync search, header capture, running sums,
// payload pass-through and end-of-frame check.
// ----------------------------------------------------------------------------
module fmp_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [fmp_pkg::BYTE_W-1:0]   rx_byte,
   input  fmp_pkg::cfg_type             cfg,
   output logic                         emit,
   output fmp_pkg::result_type          result
);

   logic [fmp_pkg::POS_W-1:0]  position_ff, position_in;
   logic [fmp_pkg::BYTE_W-1:0] length_low_ff, length_low_in;
   logic [fmp_pkg::LEN_W-1:0]  payload_length_ff, payload_length_in;
   logic [fmp_pkg::BYTE_W-1:0] current_id_ff, current_id_in;
   logic [fmp_pkg::BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [fmp_pkg::BYTE_W-1:0] sum_b_ff, sum_b_in;

   logic [fmp_pkg::BYTE_W-1:0] acc_a;
   logic [fmp_pkg::BYTE_W-1:0] acc_b;
   logic [fmp_pkg::POS_W-1:0]  frame_end;
   logic [fmp_pkg::POS_W-1:0]  pay_offset;
   logic [fmp_pkg::LEN_W-1:0]  rx_len;
   logic [fmp_pkg::BYTE_W-1:0] sync_want;

   assign acc_a      = sum_a_ff + rx_byte;
   assign acc_b      = sum_b_ff + acc_a;
   assign frame_end  = fmp_pkg::HEADER_BYTES + {1'b0, payload_length_ff};
   assign pay_offset = position_ff - fmp_pkg::HEADER_BYTES;
   assign rx_len     = {rx_byte, length_low_ff};
   assign sync_want  = (position_ff == fmp_pkg::POS_SYNC_FIRST) ? cfg.sync_first
                                                                : cfg.sync_second;

   always_comb begin
      position_in       = position_ff;
      length_low_in     = length_low_ff;
      payload_length_in = payload_length_ff;
      current_id_in     = current_id_ff;
      sum_a_in          = sum_a_ff;
      sum_b_in          = sum_b_ff;
      emit              = 1'b0;
      result.kind          = fmp_pkg::KIND_PAYLOAD;
      result.message_id    = current_id_ff;
      result.payload_byte  = '0;
      result.payload_index = '0;
      result.frame_length  = payload_length_ff;

      if (position_ff == fmp_pkg::POS_SYNC_FIRST ||
          position_ff == fmp_pkg::POS_SYNC_SECOND) begin
         // mismatching sync byte is dropped, position holds
         if (rx_byte == sync_want) begin
            sum_a_in    = acc_a;
            sum_b_in    = acc_b;
            position_in = position_ff + 1'b1;
         end
      end else if (position_ff == fmp_pkg::POS_ID) begin
         current_id_in = rx_byte;
         sum_a_in      = acc_a;
         sum_b_in      = acc_b;
         position_in   = fmp_pkg::POS_LEN_LOW;
      end else if (position_ff == fmp_pkg::POS_LEN_LOW) begin
         length_low_in = rx_byte;
         sum_a_in      = acc_a;
         sum_b_in      = acc_b;
         position_in   = fmp_pkg::POS_LEN_HIGH;
      end else if (position_ff == fmp_pkg::POS_LEN_HIGH) begin
         if (rx_len > cfg.max_payload) begin
            emit                = 1'b1;
            result.kind         = fmp_pkg::KIND_LEN_ERR;
            result.frame_length = rx_len;
            position_in         = '0;
            length_low_in       = '0;
            payload_length_in   = '0;
            sum_a_in            = '0;
            sum_b_in            = '0;
         end else begin
            payload_length_in = rx_len;
            sum_a_in          = acc_a;
            sum_b_in          = acc_b;
            position_in       = fmp_pkg::HEADER_BYTES;
         end
      end else if (position_ff < frame_end) begin
         emit                 = 1'b1;
         result.kind          = fmp_pkg::KIND_PAYLOAD;
         result.payload_byte  = rx_byte;
         result.payload_index = pay_offset[fmp_pkg::LEN_W-1:0];
         sum_a_in             = acc_a;
         sum_b_in             = acc_b;
         position_in          = position_ff + 1'b1;
      end else if (position_ff == frame_end && rx_byte == sum_a_ff) begin
         position_in = position_ff + 1'b1;
      end else begin
         // first check byte wrong, or second check byte
         emit        = 1'b1;
         result.kind = (position_ff != frame_end && rx_byte == sum_b_ff)
                       ? fmp_pkg::KIND_GOOD : fmp_pkg::KIND_CSUM_ERR;
         position_in       = '0;
         length_low_in     = '0;
         payload_length_in = '0;
         sum_a_in          = '0;
         sum_b_in          = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff       <= '0;
         length_low_ff     <= '0;
         payload_length_ff <= '0;
         current_id_ff     <= '0;
         sum_a_ff          <= '0;
         sum_b_ff          <= '0;
      end else if (step) begin
         position_ff       <= position_in;
         length_low_ff     <= length_low_in;
         payload_length_ff <= payload_length_in;
         current_id_ff     <= current_id_in;
         sum_a_ff          <= sum_a_in;
         sum_b_ff          <= sum_b_in;
      end
   end

endmodule

>>> rtl/framed_message_parser.sv
// ----------------------------------------------------------------------------
// framed_message_parser
// Byte-stream frame parser with a pair of running 8-bit check sums.
//
//   channel   dir   handshake              word
//   req_      in    req_valid/req_ready    req_rx_byte
//   rsp_      out   rsp_valid/rsp_ready    kind, id, byte, index, length
//   csr_      in    csr_write_en           csr_index, csr_wdata
//
// One byte per cycle sustained when not stalled. Bytes are parsed from the
// input register; words go to the result register. Synchronous reset clears
// frame state and valid flags and reloads the configuration, not the data
// registers. A stalled result word holds the pipe; the input register still
// takes a byte whenever the step behind it can move.
// ----------------------------------------------------------------------------
module framed_message_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fmp_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fmp_pkg::KIND_W-1:0]        rsp_kind,
   output logic [fmp_pkg::BYTE_W-1:0]        rsp_message_id,
   output logic [fmp_pkg::BYTE_W-1:0]        rsp_payload_byte,
   output logic [fmp_pkg::LEN_W-1:0]         rsp_payload_index,
   output logic [fmp_pkg::LEN_W-1:0]         rsp_frame_length,
   input  logic                              csr_write_en,
   input  logic [fmp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fmp_pkg::LEN_W-1:0]         csr_wdata
);

   fmp_pkg::cfg_type    cfg;
   fmp_pkg::result_type step_result;
   fmp_pkg::result_type rsp_ff;
   logic                step_emit;

   logic                        in_valid_ff, in_valid_in;
   logic [fmp_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_free;
   logic                        advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? step_emit : (rsp_ready ? 1'b0 : rsp_valid_ff);

   fmp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   fmp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .emit    (step_emit),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && step_emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_message_id    = rsp_ff.message_id;
   assign rsp_payload_byte  = rsp_ff.payload_byte;
   assign rsp_payload_index = rsp_ff.payload_index;
   assign rsp_frame_length  = rsp_ff.frame_length;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives framed byte streams into the framed message parser under random
// sender gaps and receiver stalls. A scoreboard tracks the frame position
// and both running sums, predicts each payload, good, checksum and length
// word, and compares the words that come out against the ones it predicts.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;

   typedef enum {
      FRAME_GOOD, FRAME_BAD_SUM_A, FRAME_BAD_SUM_B, FRAME_TOO_LONG, FRAME_CUT, LINE_NOISE
   } frame_shape_type;

   typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PULSED} ready_mode_type;

   class frame_scoreboard_type;
      fmp_pkg::cfg_type                  regs;
      logic [fmp_pkg::POS_W-1:0]         frame_pos;
      logic [fmp_pkg::BYTE_W-1:0]        len_low_byte;
      logic [fmp_pkg::LEN_W-1:0]         announced_len;
      logic [fmp_pkg::BYTE_W-1:0]        frame_id;
      logic [fmp_pkg::BYTE_W-1:0]        run_sum;
      logic [fmp_pkg::BYTE_W-1:0]        run_sum2;
      fmp_pkg::result_type               expected_words[$];
      int                                errors;
      int                                words_checked;
      int                                kind_count[4];

      function void start_over();
         frame_pos     = fmp_pkg::POS_SYNC_FIRST;
         len_low_byte  = '0;
         announced_len = '0;
         run_sum       = '0;
         run_sum2      = '0;
      endfunction

      function void power_on();
         regs.sync_first  = '0;
         regs.sync_second = '0;
         regs.max_payload = fmp_pkg::MAX_PAYLOAD_RESET;
         frame_id         = '0;
         errors           = 0;
         words_checked    = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
         start_over();
      endfunction

      function void write_reg(logic [fmp_pkg::CSR_IDX_W-1:0] idx,
                              logic [fmp_pkg::LEN_W-1:0] data);
         case (idx)
            fmp_pkg::CSR_SYNC_FIRST:  regs.sync_first  = data[fmp_pkg::BYTE_W-1:0];
            fmp_pkg::CSR_SYNC_SECOND: regs.sync_second = data[fmp_pkg::BYTE_W-1:0];
            fmp_pkg::CSR_MAX_PAYLOAD: regs.max_payload = data;
            default: ;
         endcase
      endfunction

      function void fold(logic [fmp_pkg::BYTE_W-1:0] b);
         run_sum  = run_sum + b;
         run_sum2 = run_sum2 + run_sum;
      endfunction

      // advance the frame state by one byte, queue the word it produces
      function void parse_byte(logic [fmp_pkg::BYTE_W-1:0] b);
         logic [fmp_pkg::POS_W-1:0]  frame_end;
         logic [fmp_pkg::POS_W-1:0]  offset;
         logic [fmp_pkg::LEN_W-1:0]  len;
         logic [fmp_pkg::BYTE_W-1:0] sync_want;
         fmp_pkg::result_type        word;
         bit                         emits;
         frame_end = fmp_pkg::HEADER_BYTES + {1'b0, announced_len};
         word      = '0;
         emits     = 1'b0;
         if (frame_pos == fmp_pkg::POS_SYNC_FIRST || frame_pos == fmp_pkg::POS_SYNC_SECOND) begin
            sync_want = (frame_pos == fmp_pkg::POS_SYNC_FIRST) ? regs.sync_first
                                                               : regs.sync_second;
            // a byte that misses the sync pattern is dropped, position holds
            if (b == sync_want) begin
               fold(b);
               frame_pos = frame_pos + 1'b1;
            end
         end else if (frame_pos == fmp_pkg::POS_ID) begin
            frame_id = b;
            fold(b);
            frame_pos = fmp_pkg::POS_LEN_LOW;
         end else if (frame_pos == fmp_pkg::POS_LEN_LOW) begin
            len_low_byte = b;
            fold(b);
            frame_pos = fmp_pkg::POS_LEN_HIGH;
         end else if (frame_pos == fmp_pkg::POS_LEN_HIGH) begin
            len = {b, len_low_byte};
            if (len > regs.max_payload) begin
               start_over();
               word.kind         = fmp_pkg::KIND_LEN_ERR;
               word.frame_length = len;
               emits             = 1'b1;
            end else begin
               announced_len = len;
               fold(b);
               frame_pos = fmp_pkg::HEADER_BYTES;
            end
         end else if (frame_pos < frame_end) begin
            offset = frame_pos - fmp_pkg::HEADER_BYTES;
            fold(b);
            frame_pos          = frame_pos + 1'b1;
            word.kind          = fmp_pkg::KIND_PAYLOAD;
            word.payload_byte  = b;
            word.payload_index = offset[fmp_pkg::LEN_W-1:0];
            word.frame_length  = announced_len;
            emits              = 1'b1;
         end else if (frame_pos == frame_end) begin
            // a wrong first check byte ends the frame at once
            if (b == run_sum) begin
               frame_pos = frame_pos + 1'b1;
            end else begin
               word.kind         = fmp_pkg::KIND_CSUM_ERR;
               word.frame_length = announced_len;
               start_over();
               emits = 1'b1;
            end
         end else begin
            word.kind         = (b == run_sum2) ? fmp_pkg::KIND_GOOD : fmp_pkg::KIND_CSUM_ERR;
            word.frame_length = announced_len;
            start_over();
            emits = 1'b1;
         end
         if (emits) begin
            word.message_id = frame_id;
            expected_words.insert(expected_words.size(), word);
         end
      endfunction

      function void check_word(fmp_pkg::result_type got);
         fmp_pkg::result_type want;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected word: kind %0d id %02h byte %02h index %0d length %0d",
                        got.kind, got.message_id, got.payload_byte, got.payload_index,
                        got.frame_length);
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            kind_count[want.kind]++;
            if (got.kind !== want.kind || got.message_id !== want.message_id ||
                got.payload_byte !== want.payload_byte ||
                got.payload_index !== want.payload_index ||
                got.frame_length !== want.frame_length) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("word %0d mismatch: exp kind %0d id %02h byte %02h idx %0d len %0d",
                           words_checked, want.kind, want.message_id, want.payload_byte,
                           want.payload_index, want.frame_length);
                  $display("                   got kind %0d id %02h byte %02h idx %0d len %0d",
                           got.kind, got.message_id, got.payload_byte,
                           got.payload_index, got.frame_length);
               end
            end
         end
      endfunction
   endclass

   logic                               clock        = 1'b0;
   logic                               reset        = 1'b1;
   logic                               req_valid    = 1'b0;
   logic                               req_ready;
   logic [fmp_pkg::BYTE_W-1:0]         req_rx_byte  = '0;
   logic                               rsp_valid;
   logic                               rsp_ready    = 1'b0;
   logic [fmp_pkg::KIND_W-1:0]         rsp_kind;
   logic [fmp_pkg::BYTE_W-1:0]         rsp_message_id;
   logic [fmp_pkg::BYTE_W-1:0]         rsp_payload_byte;
   logic [fmp_pkg::LEN_W-1:0]          rsp_payload_index;
   logic [fmp_pkg::LEN_W-1:0]          rsp_frame_length;
   logic                               csr_write_en = 1'b0;
   logic [fmp_pkg::CSR_IDX_W-1:0]      csr_index    = fmp_pkg::CSR_SYNC_FIRST;
   logic [fmp_pkg::LEN_W-1:0]          csr_wdata    = '0;

   frame_scoreboard_type               sb;
   logic [fmp_pkg::BYTE_W-1:0]         tx_q[$];
   logic [fmp_pkg::BYTE_W-1:0]         tx_sum_a;
   logic [fmp_pkg::BYTE_W-1:0]         tx_sum_b;
   logic [fmp_pkg::BYTE_W-1:0]         cur_sync1 = '0;
   logic [fmp_pkg::BYTE_W-1:0]         cur_sync2 = '0;
   logic [fmp_pkg::LEN_W-1:0]          cur_max   = fmp_pkg::MAX_PAYLOAD_RESET;
   int                                 burst_left = 0;
   int                                 bytes_in   = 0;
   int                                 settings_used = 1;
   int                                 idle_cycles = 0;
   ready_mode_type                     ready_mode = READY_ALWAYS;
   int                                 mode_left  = 0;
   int                                 pulse_count = 0;

   framed_message_parser u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_message_id    (rsp_message_id),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_length  (rsp_frame_length),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver: stretches of always-ready, light, heavy and periodic stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 160);
      end else begin
         mode_left--;
      end
      pulse_count++;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_RARELY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= pulse_count[2];
      endcase
   end

   // monitor and watchdog
   always @(posedge clock) begin
      fmp_pkg::result_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.parse_byte(req_rx_byte);
            bytes_in++;
         end
         if (rsp_valid && rsp_ready) begin
            got.kind          = rsp_kind;
            got.message_id    = rsp_message_id;
            got.payload_byte  = rsp_payload_byte;
            got.payload_index = rsp_payload_index;
            got.frame_length  = rsp_frame_length;
            sb.check_word(got);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAIL framed_message_parser");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [fmp_pkg::BYTE_W-1:0] b);
      int gap;
      int roll;
      if (burst_left == 0) begin
         roll = $urandom_range(0, 9);
         if (roll < 4)      gap = 0;
         else if (roll < 8) gap = $urandom_range(1, 3);
         else               gap = $urandom_range(4, 12);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_queue();
      foreach (tx_q[i]) send_byte(tx_q[i]);
   endtask

   function automatic void put(logic [fmp_pkg::BYTE_W-1:0] b);
      tx_q.insert(tx_q.size(), b);
      tx_sum_a = tx_sum_a + b;
      tx_sum_b = tx_sum_b + tx_sum_a;
   endfunction

   function automatic void open_frame(logic [fmp_pkg::BYTE_W-1:0] id,
                                      logic [fmp_pkg::LEN_W-1:0] len);
      tx_sum_a = '0;
      tx_sum_b = '0;
      put(cur_sync1);
      put(cur_sync2);
      put(id);
      put(len[7:0]);
      put(len[15:8]);
   endfunction

   function automatic void add_checks(frame_shape_type shape);
      case (shape)
         FRAME_BAD_SUM_A: tx_q.insert(tx_q.size(), tx_sum_a ^ 8'($urandom_range(1, 255)));
         FRAME_BAD_SUM_B: begin
            tx_q.insert(tx_q.size(), tx_sum_a);
            tx_q.insert(tx_q.size(), tx_sum_b ^ 8'($urandom_range(1, 255)));
         end
         default: begin
            tx_q.insert(tx_q.size(), tx_sum_a);
            tx_q.insert(tx_q.size(), tx_sum_b);
         end
      endcase
   endfunction

   // mostly short payloads, now and then the largest the limit allows, up to 300
   function automatic logic [fmp_pkg::LEN_W-1:0] pick_length();
      int cap;
      int roll;
      cap  = (cur_max > 300) ? 300 : int'(cur_max);
      roll = $urandom_range(0, 99);
      if (roll < 75)      return 16'($urandom_range(0, (cap < 8) ? cap : 8));
      else if (roll < 95) return 16'($urandom_range(0, (cap < 40) ? cap : 40));
      else                return 16'(cap);
   endfunction

   task automatic build_frame(input frame_shape_type shape);
      logic [fmp_pkg::LEN_W-1:0] len;
      int                        keep;
      tx_q.delete();
      if (shape == LINE_NOISE) begin
         repeat ($urandom_range(1, 6)) tx_q.insert(tx_q.size(), 8'($urandom));
      end else if (shape == FRAME_TOO_LONG) begin
         if ($urandom_range(0, 1) == 0) len = cur_max + 16'd1;
         else len = 16'($urandom_range(65535, int'(cur_max) + 1));
         open_frame(8'($urandom), len);
      end else begin
         len = pick_length();
         open_frame(8'($urandom), len);
         repeat (len) put(8'($urandom));
         add_checks(shape);
         if (shape == FRAME_CUT) begin
            keep = $urandom_range(1, tx_q.size() - 1);
            tx_q = tx_q[0:keep-1];
         end
      end
   endtask

   task automatic run_random(input int target);
      int              sent;
      int              roll;
      frame_shape_type shape;
      sent = 0;
      while (sent < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 68)      shape = FRAME_GOOD;
         else if (roll < 76) shape = FRAME_BAD_SUM_A;
         else if (roll < 84) shape = FRAME_BAD_SUM_B;
         else if (roll < 90) shape = (cur_max == 16'hFFFF) ? FRAME_GOOD : FRAME_TOO_LONG;
         else if (roll < 95) shape = FRAME_CUT;
         else                shape = LINE_NOISE;
         build_frame(shape);
         if (shape != LINE_NOISE) sent += tx_q.size();
         send_queue();
      end
   endtask

   // stop sending and let every outstanding word and byte leave the block
   task automatic finish_phase();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input logic [fmp_pkg::BYTE_W-1:0] s1,
                           input logic [fmp_pkg::BYTE_W-1:0] s2,
                           input logic [fmp_pkg::LEN_W-1:0] max_len);
      csr_write_en <= 1'b1;
      csr_index    <= fmp_pkg::CSR_SYNC_FIRST;
      csr_wdata    <= {8'd0, s1};
      @(posedge clock);
      csr_index    <= fmp_pkg::CSR_SYNC_SECOND;
      csr_wdata    <= {8'd0, s2};
      @(posedge clock);
      csr_index    <= fmp_pkg::CSR_MAX_PAYLOAD;
      csr_wdata    <= max_len;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.write_reg(fmp_pkg::CSR_SYNC_FIRST, {8'd0, s1});
      sb.write_reg(fmp_pkg::CSR_SYNC_SECOND, {8'd0, s2});
      sb.write_reg(fmp_pkg::CSR_MAX_PAYLOAD, max_len);
      cur_sync1 = s1;
      cur_sync2 = s2;
      cur_max   = max_len;
      settings_used++;
   endtask

   initial begin
      sb = new();
      sb.power_on();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: sync misses before and between the sync
      // bytes, an empty good frame, one length over the limit, a bad first
      // and a bad second check byte
      tx_q.delete();
      tx_sum_a = '0;
      tx_sum_b = '0;
      tx_q.insert(tx_q.size(), 8'hFF);
      put(cur_sync1);
      tx_q.insert(tx_q.size(), 8'hFF);
      put(cur_sync2);
      put(8'hFF);
      put(8'h00);
      put(8'h00);
      add_checks(FRAME_GOOD);
      send_queue();
      tx_q.delete();
      open_frame(8'h00, fmp_pkg::MAX_PAYLOAD_RESET + 16'd1);
      open_frame(8'h3C, 16'd2);
      put(8'hFF);
      put(8'h00);
      add_checks(FRAME_BAD_SUM_A);
      open_frame(8'hC3, 16'd0);
      add_checks(FRAME_BAD_SUM_B);
      send_queue();

      run_random(250);
      finish_phase();

      set_regs(8'hA5, 8'h5A, 16'd0);
      run_random(150);
      finish_phase();

      set_regs(8'hFF, 8'hFF, 16'hFFFF);
      run_random(250);
      finish_phase();

      set_regs(8'($urandom), 8'($urandom), 16'd7);
      run_random(200);
      finish_phase();

      set_regs(8'($urandom), 8'($urandom), 16'($urandom_range(8, 300)));
      run_random(200);
      finish_phase();

      $display("%0d bytes over %0d register settings; %0d words checked", bytes_in,
               settings_used, sb.words_checked);
      $display("payload %0d, good frames %0d, checksum errors %0d, length errors %0d",
               sb.kind_count[fmp_pkg::KIND_PAYLOAD], sb.kind_count[fmp_pkg::KIND_GOOD],
               sb.kind_count[fmp_pkg::KIND_CSUM_ERR], sb.kind_count[fmp_pkg::KIND_LEN_ERR]);
      if (sb.expected_words.size() != 0)
         $display("%0d expected words never arrived", sb.expected_words.size());
      if (sb.errors > MAX_REPORTS)
         $display("%0d mismatches in total", sb.errors);
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("PASS framed_message_parser");
      end else begin
         $display("FAIL framed_message_parser");
      end
      $finish;
   end

endmodule

>>> framed_message_parser.f
rtl/fmp_pkg.sv
rtl/fmp_csr.sv
rtl/fmp_parser.sv
rtl/framed_message_parser.sv
tb/testbench.sv
